// ===== rtl/lkv_pkg.sv =====
package lkv_pkg;

    // Q2.30 axis fraction bits
    localparam int AXIS_FRAC = 30;
    // magnitude width of an input vector to the normalizer
    localparam int MAG_W     = 63;
    // width of the sum of three squares
    localparam int SQ_W      = 62;
    // root bits, one per square-root stage
    localparam int ROOT_W    = 31;
    // quotient bits, one per divide stage
    localparam int QUO_W     = 31;
    // dividend and remainder widths in the divider
    localparam int NUM_W     = 61;
    localparam int REM_W     = 62;
    // normalizer stages: 7 front stages, root, dividend, divide, sign
    localparam int PRE_LAT   = 7;
    localparam int NORM_LAT  = PRE_LAT + ROOT_W + 1 + QUO_W + 1;

    typedef logic [AXIS_FRAC-1:0] t_mag;
    typedef logic [2:0][31:0]     t_axis3;
    typedef logic [2:0][63:0]     t_wide3;

    // side data carried alongside the square root
    typedef struct packed {
        logic            zero;
        logic [2:0]      neg;
        logic [2:0][AXIS_FRAC-1:0] mg;
    } t_nside;

endpackage

// ===== rtl/lkv_isqrt.sv =====
module lkv_isqrt import lkv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [SQ_W-1:0]   i_s,
    input  t_nside            i_side,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root,
    output t_nside            o_side
);

    localparam int RS_W = SQ_W + 1;

    logic [RS_W-1:0]   r_rem  [ROOT_W];
    logic [RS_W-1:0]   r_res  [ROOT_W];
    t_nside            r_side [ROOT_W];
    logic [ROOT_W-1:0] r_vld;

    // one result bit per stage, restoring square root
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stg
        localparam logic [RS_W-1:0] BIT = RS_W'(1) << (2 * (ROOT_W - 1 - k));
        logic [RS_W-1:0] w_rem_in;
        logic [RS_W-1:0] w_res_in;
        logic [RS_W-1:0] w_trial;
        t_nside          w_side_in;
        logic            w_vld_in;

        if (k == 0) begin : g_first
            assign w_rem_in  = RS_W'(i_s);
            assign w_res_in  = '0;
            assign w_side_in = i_side;
            assign w_vld_in  = i_vld;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_res_in  = r_res[k-1];
            assign w_side_in = r_side[k-1];
            assign w_vld_in  = r_vld[k-1];
        end

        assign w_trial = w_res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= w_side_in;
                if (w_rem_in >= w_trial) begin
                    r_rem[k] <= w_rem_in - w_trial;
                    r_res[k] <= (w_res_in >> 1) + BIT;
                end else begin
                    r_rem[k] <= w_rem_in;
                    r_res[k] <= w_res_in >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_res[ROOT_W-1][ROOT_W-1:0];
    assign o_side = r_side[ROOT_W-1];

endmodule

// ===== rtl/lkv_div.sv =====
module lkv_div import lkv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [ROOT_W-1:0] i_den,
    input  logic              i_neg,
    input  logic              i_zero,
    output logic              o_vld,
    output logic [QUO_W-1:0]  o_q,
    output logic              o_neg,
    output logic              o_zero
);

    logic [REM_W-1:0]  r_rem  [QUO_W];
    logic [ROOT_W-1:0] r_den  [QUO_W];
    logic [QUO_W-1:0]  r_q    [QUO_W];
    logic [QUO_W-1:0]  r_neg;
    logic [QUO_W-1:0]  r_zero;
    logic [QUO_W-1:0]  r_vld;

    // one quotient bit per stage, restoring division, msb first
    for (genvar k = 0; k < QUO_W; k++) begin : g_stg
        localparam int SH = QUO_W - 1 - k;
        logic [REM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_den_in;
        logic [QUO_W-1:0]  w_q_in;
        logic [QUO_W-1:0]  n_q;
        logic [REM_W-1:0]  w_dsh;
        logic              w_neg_in;
        logic              w_zero_in;
        logic              w_vld_in;

        if (k == 0) begin : g_first
            assign w_rem_in  = REM_W'(i_num);
            assign w_den_in  = i_den;
            assign w_q_in    = '0;
            assign w_neg_in  = i_neg;
            assign w_zero_in = i_zero;
            assign w_vld_in  = i_vld;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_den_in  = r_den[k-1];
            assign w_q_in    = r_q[k-1];
            assign w_neg_in  = r_neg[k-1];
            assign w_zero_in = r_zero[k-1];
            assign w_vld_in  = r_vld[k-1];
        end

        assign w_dsh = REM_W'(w_den_in) << SH;

        always_comb begin
            n_q     = w_q_in;
            n_q[SH] = (w_rem_in >= w_dsh);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k]  <= w_den_in;
                r_q[k]    <= n_q;
                r_neg[k]  <= w_neg_in;
                r_zero[k] <= w_zero_in;
                r_rem[k]  <= n_q[SH] ? (w_rem_in - w_dsh) : w_rem_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end
    end

    assign o_vld  = r_vld[QUO_W-1];
    assign o_q    = r_q[QUO_W-1];
    assign o_neg  = r_neg[QUO_W-1];
    assign o_zero = r_zero[QUO_W-1];

endmodule

// ===== rtl/lkv_norm.sv =====
module lkv_norm import lkv_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_vld,
    input  t_wide3 i_vec,
    output logic   o_vld,
    output t_axis3 o_unit
);

    logic [MAG_W-1:0] r1_mg [3];
    logic [2:0]       r1_neg;
    logic [MAG_W-1:0] r2_mg [3];
    logic [MAG_W-1:0] r2_m;
    logic [2:0]       r2_neg;
    logic [MAG_W-1:0] r3_mg [3];
    logic [2:0]       r3_neg;
    logic [7:0]       r3_gnz;
    logic [2:0]       r3_gpos [8];
    logic [MAG_W-1:0] r4_mg [3];
    logic [2:0]       r4_neg;
    logic [5:0]       r4_p;
    logic             r4_zero;
    t_nside           r5_side;
    t_nside           r6_side;
    logic [2*AXIS_FRAC-1:0] r6_sq [3];
    t_nside           r7_side;
    logic [SQ_W-1:0]  r7_s;
    logic [NUM_W-1:0] r8_num [3];
    logic [ROOT_W-1:0] r8_den;
    logic [2:0]       r8_neg;
    logic             r8_zero;
    logic [PRE_LAT:1] r_v;
    logic             r8_v;
    t_axis3           r_unit;
    logic             r_out_v;

    logic [MAG_W-1:0] n2_m;
    logic [63:0]      w_m64;
    logic [7:0]       n3_gnz;
    logic [2:0]       n3_gpos [8];
    logic [5:0]       n4_p;
    t_nside           n5_side;
    logic [MAG_W-1:0] w_sh [3];

    logic              w_rt_vld;
    logic [ROOT_W-1:0] w_root;
    t_nside            w_rt_side;
    logic [2:0]        w_dv_vld;
    logic [QUO_W-1:0]  w_q [3];
    logic [2:0]        w_dv_neg;
    logic [2:0]        w_dv_zero;

    // S1: sign and magnitude
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_neg[i] <= i_vec[i][63];
                r1_mg[i]  <= i_vec[i][63] ? MAG_W'(-i_vec[i]) : i_vec[i][MAG_W-1:0];
            end
        end
    end

    // S2: largest magnitude
    always_comb begin
        n2_m = r1_mg[0];
        if (r1_mg[1] > n2_m) begin
            n2_m = r1_mg[1];
        end
        if (r1_mg[2] > n2_m) begin
            n2_m = r1_mg[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_mg  <= r1_mg;
            r2_neg <= r1_neg;
            r2_m   <= n2_m;
        end
    end

    // S3: leading one within each byte
    assign w_m64 = {1'b0, r2_m};

    always_comb begin
        for (int g = 0; g < 8; g++) begin
            n3_gnz[g]  = |w_m64[g*8 +: 8];
            n3_gpos[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (w_m64[g*8 + b]) begin
                    n3_gpos[g] = 3'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_mg   <= r2_mg;
            r3_neg  <= r2_neg;
            r3_gnz  <= n3_gnz;
            r3_gpos <= n3_gpos;
        end
    end

    // S4: pick the top nonzero byte
    always_comb begin
        n4_p = '0;
        for (int g = 0; g < 8; g++) begin
            if (r3_gnz[g]) begin
                n4_p = {3'(g), r3_gpos[g]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_mg   <= r3_mg;
            r4_neg  <= r3_neg;
            r4_p    <= n4_p;
            r4_zero <= ~|r3_gnz;
        end
    end

    // S5: common shift bringing the largest magnitude to [2^29, 2^30)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r4_p > 6'(AXIS_FRAC - 1)) begin
                w_sh[i] = r4_mg[i] >> (r4_p - 6'(AXIS_FRAC - 1));
            end else begin
                w_sh[i] = r4_mg[i] << (6'(AXIS_FRAC - 1) - r4_p);
            end
            n5_side.mg[i] = w_sh[i][AXIS_FRAC-1:0];
        end
        n5_side.neg  = r4_neg;
        n5_side.zero = r4_zero;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_side <= n5_side;
        end
    end

    // S6: squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_side <= r5_side;
            for (int i = 0; i < 3; i++) begin
                r6_sq[i] <= r5_side.mg[i] * r5_side.mg[i];
            end
        end
    end

    // S7: sum of squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_side <= r6_side;
            r7_s    <= SQ_W'(r6_sq[0]) + SQ_W'(r6_sq[1]) + SQ_W'(r6_sq[2]);
        end
    end

    // front stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[PRE_LAT-1:1], i_vld};
        end
    end

    lkv_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_vld   (r_v[PRE_LAT]),
        .i_s     (r7_s),
        .i_side  (r7_side),
        .o_vld   (w_rt_vld),
        .o_root  (w_root),
        .o_side  (w_rt_side)
    );

    // dividend with half the divisor added for rounding
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r8_num[i] <= NUM_W'({w_rt_side.mg[i], {AXIS_FRAC{1'b0}}})
                           + NUM_W'(w_root[ROOT_W-1:1]);
            end
            r8_den  <= w_root;
            r8_neg  <= w_rt_side.neg;
            r8_zero <= w_rt_side.zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (i_en) begin
            r8_v <= w_rt_vld;
        end
    end

    // one divider lane per component
    for (genvar i = 0; i < 3; i++) begin : g_lane
        lkv_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_vld   (r8_v),
            .i_num   (r8_num[i]),
            .i_den   (r8_den),
            .i_neg   (r8_neg[i]),
            .i_zero  (r8_zero),
            .o_vld   (w_dv_vld[i]),
            .o_q     (w_q[i]),
            .o_neg   (w_dv_neg[i]),
            .o_zero  (w_dv_zero[i])
        );
    end

    // sign restore, zero-length vector gives zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_dv_zero[i]) begin
                    r_unit[i] <= '0;
                end else if (w_dv_neg[i]) begin
                    r_unit[i] <= -32'(w_q[i]);
                end else begin
                    r_unit[i] <= 32'(w_q[i]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= w_dv_vld[0];
        end
    end

    assign o_vld  = r_out_v;
    assign o_unit = r_unit;

endmodule

// ===== rtl/look_at_view_matrix_top.sv =====
// Look-at view matrix, left handed, fixed point.
// Input channel (i_valid / o_ready) carries one camera setup per transaction:
// camera, gaze point and up vector, each component signed Q16.16.
// Output channel (o_valid / i_ready) returns the unit x, y and sight axes in
// Q2.30 and the three negated axis-camera dot products in Q16.16, saturated.
// Each axis comes from a 71-stage normalizer (shift, sum of squares, a
// 31-stage square root, a 31-stage divide per component); the three
// normalizers run in series with two cross-product stages between them and
// four dot-product stages after the last one.
// Throughput: one transaction per cycle while the receiver does not stall.
// The whole pipeline advances on one enable: it moves whenever the output
// register is empty or being taken. While the receiver holds i_ready low with
// a result waiting, o_ready is low and every stage holds its contents.
// Synchronous active-low reset clears all valid bits; data registers are not
// reset.
module look_at_view_matrix_top import lkv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_cam_x,
    input  logic [31:0] i_cam_y,
    input  logic [31:0] i_cam_z,
    input  logic [31:0] i_gaze_x,
    input  logic [31:0] i_gaze_y,
    input  logic [31:0] i_gaze_z,
    input  logic [31:0] i_up_x,
    input  logic [31:0] i_up_y,
    input  logic [31:0] i_up_z,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_right_x,
    output logic [31:0] o_right_y,
    output logic [31:0] o_right_z,
    output logic [31:0] o_upward_x,
    output logic [31:0] o_upward_y,
    output logic [31:0] o_upward_z,
    output logic [31:0] o_view_x,
    output logic [31:0] o_view_y,
    output logic [31:0] o_view_z,
    output logic [31:0] o_shift_x,
    output logic [31:0] o_shift_y,
    output logic [31:0] o_shift_z
);

    localparam int L = NORM_LAT;

    logic   w_en;

    // stage A and delay lines
    logic   r_va;
    t_wide3 r_d;
    t_axis3 r_cam_ln [3*L+5];
    t_axis3 r_up_ln  [L+1];
    t_axis3 r_s_ln   [2*L+4];
    t_axis3 r_x_ln   [L+2];

    // normalizer outputs
    logic   w_n1_vld, w_n2_vld, w_n3_vld;
    t_axis3 w_sight, w_xa, w_ya;

    // cross products
    logic signed [63:0] r_x1p [6];
    logic signed [63:0] r_y1p [6];
    t_wide3             r_x2c;
    t_wide3             r_y2c;
    logic               r_x1_v, r_x2_v, r_y1_v, r_y2_v;
    t_axis3             w_ca, w_cb, w_ya_a, w_ya_b;

    // dot products, axis order x, y, sight
    logic signed [63:0] r_d1p [3][3];
    logic signed [65:0] r_d2s [3];
    logic [65:0]        r_d3_mag [3];
    logic [2:0]         r_d3_pos;
    t_axis3             r_d1_ax [3];
    t_axis3             r_d2_ax [3];
    t_axis3             r_d3_ax [3];
    t_axis3             r_d4_ax [3];
    logic [31:0]        r_d4_sh [3];
    logic               r_d1_v, r_d2_v, r_d3_v, r_d4_v;
    t_axis3             w_ax [3];
    t_axis3             w_cam_d;
    logic [65:0]        w_rnd [3];
    logic [35:0]        w_rm [3];
    logic [31:0]        n_sh [3];

    assign w_en    = !r_d4_v || i_ready;
    assign o_ready = w_en;

    // stage A: sight difference, line heads
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d[0] <= 64'($signed(i_gaze_x)) - 64'($signed(i_cam_x));
            r_d[1] <= 64'($signed(i_gaze_y)) - 64'($signed(i_cam_y));
            r_d[2] <= 64'($signed(i_gaze_z)) - 64'($signed(i_cam_z));
            r_cam_ln[0] <= {i_cam_z, i_cam_y, i_cam_x};
            r_up_ln[0]  <= {i_up_z, i_up_y, i_up_x};
            r_s_ln[0]   <= w_sight;
            r_x_ln[0]   <= w_xa;
            for (int k = 1; k < 3*L+5; k++) begin
                r_cam_ln[k] <= r_cam_ln[k-1];
            end
            for (int k = 1; k < L+1; k++) begin
                r_up_ln[k] <= r_up_ln[k-1];
            end
            for (int k = 1; k < 2*L+4; k++) begin
                r_s_ln[k] <= r_s_ln[k-1];
            end
            for (int k = 1; k < L+2; k++) begin
                r_x_ln[k] <= r_x_ln[k-1];
            end
        end
    end

    lkv_norm u_norm_sight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_va),
        .i_vec   (r_d),
        .o_vld   (w_n1_vld),
        .o_unit  (w_sight)
    );

    // up x sight
    assign w_ca = r_up_ln[L];
    assign w_cb = w_sight;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1p[0] <= $signed(w_ca[1]) * $signed(w_cb[2]);
            r_x1p[1] <= $signed(w_ca[2]) * $signed(w_cb[1]);
            r_x1p[2] <= $signed(w_ca[2]) * $signed(w_cb[0]);
            r_x1p[3] <= $signed(w_ca[0]) * $signed(w_cb[2]);
            r_x1p[4] <= $signed(w_ca[0]) * $signed(w_cb[1]);
            r_x1p[5] <= $signed(w_ca[1]) * $signed(w_cb[0]);
            r_x2c[0] <= r_x1p[0] - r_x1p[1];
            r_x2c[1] <= r_x1p[2] - r_x1p[3];
            r_x2c[2] <= r_x1p[4] - r_x1p[5];
        end
    end

    lkv_norm u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_x2_v),
        .i_vec   (r_x2c),
        .o_vld   (w_n2_vld),
        .o_unit  (w_xa)
    );

    // sight x right
    assign w_ya_a = r_s_ln[L+1];
    assign w_ya_b = w_xa;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_y1p[0] <= $signed(w_ya_a[1]) * $signed(w_ya_b[2]);
            r_y1p[1] <= $signed(w_ya_a[2]) * $signed(w_ya_b[1]);
            r_y1p[2] <= $signed(w_ya_a[2]) * $signed(w_ya_b[0]);
            r_y1p[3] <= $signed(w_ya_a[0]) * $signed(w_ya_b[2]);
            r_y1p[4] <= $signed(w_ya_a[0]) * $signed(w_ya_b[1]);
            r_y1p[5] <= $signed(w_ya_a[1]) * $signed(w_ya_b[0]);
            r_y2c[0] <= r_y1p[0] - r_y1p[1];
            r_y2c[1] <= r_y1p[2] - r_y1p[3];
            r_y2c[2] <= r_y1p[4] - r_y1p[5];
        end
    end

    lkv_norm u_norm_upward (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_y2_v),
        .i_vec   (r_y2c),
        .o_vld   (w_n3_vld),
        .o_unit  (w_ya)
    );

    // D1: axis by camera products
    assign w_ax[0] = r_x_ln[L+1];
    assign w_ax[1] = w_ya;
    assign w_ax[2] = r_s_ln[2*L+3];
    assign w_cam_d = r_cam_ln[3*L+4];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1_ax <= w_ax;
            for (int a = 0; a < 3; a++) begin
                for (int c = 0; c < 3; c++) begin
                    r_d1p[a][c] <= $signed(w_ax[a][c]) * $signed(w_cam_d[c]);
                end
            end
        end
    end

    // D2: dot sums; D3: magnitude and sign of the negated sum
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2_ax <= r_d1_ax;
            r_d3_ax <= r_d2_ax;
            for (int a = 0; a < 3; a++) begin
                r_d2s[a] <= 66'(r_d1p[a][0]) + 66'(r_d1p[a][1]) + 66'(r_d1p[a][2]);
                r_d3_pos[a] <= (r_d2s[a] <= 66'sd0);
                r_d3_mag[a] <= r_d2s[a][65] ? 66'(-r_d2s[a]) : 66'(r_d2s[a]);
            end
        end
    end

    // D4: round half away from zero, saturate to 32 bits
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_rnd[a] = r_d3_mag[a] + (66'd1 << (AXIS_FRAC - 1));
            w_rm[a]  = w_rnd[a][65:AXIS_FRAC];
            if (r_d3_pos[a]) begin
                n_sh[a] = (w_rm[a] > 36'h07FFFFFFF) ? 32'h7FFFFFFF : w_rm[a][31:0];
            end else begin
                n_sh[a] = (w_rm[a] > 36'h080000000) ? 32'h80000000 : -w_rm[a][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d4_ax <= r_d3_ax;
            r_d4_sh <= n_sh;
        end
    end

    // valid bits of the top-level stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va   <= 1'b0;
            r_x1_v <= 1'b0;
            r_x2_v <= 1'b0;
            r_y1_v <= 1'b0;
            r_y2_v <= 1'b0;
            r_d1_v <= 1'b0;
            r_d2_v <= 1'b0;
            r_d3_v <= 1'b0;
            r_d4_v <= 1'b0;
        end else if (w_en) begin
            r_va   <= i_valid;
            r_x1_v <= w_n1_vld;
            r_x2_v <= r_x1_v;
            r_y1_v <= w_n2_vld;
            r_y2_v <= r_y1_v;
            r_d1_v <= w_n3_vld;
            r_d2_v <= r_d1_v;
            r_d3_v <= r_d2_v;
            r_d4_v <= r_d3_v;
        end
    end

    assign o_valid    = r_d4_v;
    assign o_right_x  = r_d4_ax[0][0];
    assign o_right_y  = r_d4_ax[0][1];
    assign o_right_z  = r_d4_ax[0][2];
    assign o_upward_x = r_d4_ax[1][0];
    assign o_upward_y = r_d4_ax[1][1];
    assign o_upward_z = r_d4_ax[1][2];
    assign o_view_x   = r_d4_ax[2][0];
    assign o_view_y   = r_d4_ax[2][1];
    assign o_view_z   = r_d4_ax[2][2];
    assign o_shift_x  = r_d4_sh[0];
    assign o_shift_y  = r_d4_sh[1];
    assign o_shift_z  = r_d4_sh[2];

endmodule

// ===== sim/tb_look_at_view_matrix_top.sv =====
`timescale 1ns / 1ps

module tb_look_at_view_matrix_top import lkv_pkg::*;;

    // wait after the scoreboard empties, before the summary
    localparam int PIPE_LAT  = 221;
    localparam int WD_LIMIT  = 20000;
    localparam int RAND_ITEMS = 450;

    // idle phases
    typedef enum logic [1:0] {
        PH_NONE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH
    } t_phase;

    typedef struct packed {
        logic [2:0][31:0] cam;
        logic [2:0][31:0] gaze;
        logic [2:0][31:0] up;
    } t_setup;

    typedef struct packed {
        logic [2:0][31:0] rgt;
        logic [2:0][31:0] upw;
        logic [2:0][31:0] vw;
        logic [2:0][31:0] shf;
    } t_frame;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_cam_x, i_cam_y, i_cam_z;
    logic [31:0] i_gaze_x, i_gaze_y, i_gaze_z;
    logic [31:0] i_up_x, i_up_y, i_up_z;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_right_x, o_right_y, o_right_z;
    logic [31:0] o_upward_x, o_upward_y, o_upward_z;
    logic [31:0] o_view_x, o_view_y, o_view_z;
    logic [31:0] o_shift_x, o_shift_y, o_shift_z;

    t_setup  setup_q[$];
    t_frame  frame_q[$];
    t_phase  phase;
    logic    hold_src;
    logic    stim_done;
    logic    in_acc;
    int      err_cnt;
    int      idle_cnt;

    look_at_view_matrix_top uut (.*);

    // clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // integer square root, rounded down
    function automatic logic [63:0] isqrt(logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > s) bt = bt >> 2;
        while (bt != 0) begin
            if (s >= res + bt) begin
                s   = s - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // scale to unit length in Q2.30
    function automatic t_wide3 unit_vec(t_wide3 v);
        logic [63:0] mg[3];
        logic        ng[3];
        logic [63:0] m, s, n, q;
        t_wide3      r;
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            ng[i] = v[i][63];
            mg[i] = ng[i] ? -v[i] : v[i];
            if (mg[i] > m) m = mg[i];
        end
        r = '0;
        if (m == 0) return r;
        while (m >= (64'd1 << AXIS_FRAC)) begin
            for (int i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
            m = m >> 1;
        end
        while (m < (64'd1 << (AXIS_FRAC - 1))) begin
            for (int i = 0; i < 3; i++) mg[i] = mg[i] << 1;
            m = m << 1;
        end
        for (int i = 0; i < 3; i++) s = s + mg[i] * mg[i];
        n = isqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((mg[i] << AXIS_FRAC) + n / 2) / n;
            r[i] = ng[i] ? -q : q;
        end
        return r;
    endfunction

    function automatic t_wide3 cross_prod(t_wide3 a, t_wide3 b);
        t_wide3 r;
        r[0] = $signed(a[1]) * $signed(b[2]) - $signed(a[2]) * $signed(b[1]);
        r[1] = $signed(a[2]) * $signed(b[0]) - $signed(a[0]) * $signed(b[2]);
        r[2] = $signed(a[0]) * $signed(b[1]) - $signed(a[1]) * $signed(b[0]);
        return r;
    endfunction

    // -dot(axis, cam), rounded half away from zero, saturated
    function automatic logic [31:0] cam_shift(t_wide3 ax, t_wide3 cam);
        logic signed [63:0] sum, ng;
        logic [63:0] mag, rm;
        sum = $signed(ax[0]) * $signed(cam[0]) + $signed(ax[1]) * $signed(cam[1])
            + $signed(ax[2]) * $signed(cam[2]);
        ng  = -sum;
        mag = ng < 0 ? -ng : ng;
        rm  = (mag + (64'd1 << (AXIS_FRAC - 1))) >> AXIS_FRAC;
        if (ng >= 0) return rm > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : rm[31:0];
        return rm > 64'h8000_0000 ? 32'h8000_0000 : 32'(-rm);
    endfunction

    function automatic t_frame view_frame(t_setup su);
        t_wide3 cam, up, d, sight, xa, ya;
        t_frame f;
        for (int i = 0; i < 3; i++) begin
            cam[i] = {{32{su.cam[i][31]}}, su.cam[i]};
            up[i]  = {{32{su.up[i][31]}}, su.up[i]};
            d[i]   = {{32{su.gaze[i][31]}}, su.gaze[i]} - cam[i];
        end
        sight = unit_vec(d);
        xa    = unit_vec(cross_prod(up, sight));
        ya    = unit_vec(cross_prod(sight, xa));
        for (int i = 0; i < 3; i++) begin
            f.rgt[i] = xa[i][31:0];
            f.upw[i] = ya[i][31:0];
            f.vw[i]  = sight[i][31:0];
        end
        f.shf[0] = cam_shift(xa, cam);
        f.shf[1] = cam_shift(ya, cam);
        f.shf[2] = cam_shift(sight, cam);
        return f;
    endfunction

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) << 16;
            2: return 32'($signed($urandom_range(0, 64)) - 32);
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 200000)) - 100000) << 8;
        endcase
    endfunction

    function automatic t_setup rnd_setup();
        t_setup su;
        for (int i = 0; i < 3; i++) begin
            su.cam[i]  = rnd_coord();
            su.gaze[i] = rnd_coord();
            su.up[i]   = rnd_coord();
        end
        // some degenerate shapes: gaze on camera, up along sight, zero up
        case ($urandom_range(0, 19))
            0: su.gaze = su.cam;
            1: for (int i = 0; i < 3; i++) su.up[i] = su.gaze[i] - su.cam[i];
            2: su.up = '0;
            default: ;
        endcase
        return su;
    endfunction

    function automatic t_setup mk(int cx, int cy, int cz, int gx, int gy, int gz,
                                  int ux, int uy, int uz);
        t_setup su;
        su.cam  = {32'(cz), 32'(cy), 32'(cx)};
        su.gaze = {32'(gz), 32'(gy), 32'(gx)};
        su.up   = {32'(uz), 32'(uy), 32'(ux)};
        return su;
    endfunction

    // driver: present queued setups, change at falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_acc) begin
            if (setup_q.size() > 0 && !hold_src &&
                !(phase == PH_SRC_IDLE && $urandom_range(0, 99) < 86) &&
                !(phase == PH_BOTH && $urandom_range(0, 99) < 24)) begin
                i_valid  <= 1'b1;
                {i_cam_z, i_cam_y, i_cam_x}    <= setup_q[0].cam;
                {i_gaze_z, i_gaze_y, i_gaze_x} <= setup_q[0].gaze;
                {i_up_z, i_up_y, i_up_x}       <= setup_q[0].up;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (phase == PH_SNK_STALL)
            i_ready <= $urandom_range(0, 99) >= 86;
        else if (phase == PH_BOTH)
            i_ready <= $urandom_range(0, 99) >= 24;
        else
            i_ready <= 1'b1;
    end

    // input transaction seen at this edge, for the driver
    always @(posedge i_clk) begin
        in_acc <= i_rst_n && i_valid && o_ready;
    end

    // input transaction: predict; output transaction: compare; watchdog
    always @(posedge i_clk) begin
        t_frame ex;
        t_frame got;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                frame_q.push_back(view_frame(setup_q.pop_front()));
            end
            if (o_valid && i_ready) begin
                if (frame_q.size() == 0) begin
                    $error("result with nothing expected");
                    err_cnt++;
                end else begin
                    ex = frame_q.pop_front();
                    got.rgt = {o_right_z, o_right_y, o_right_x};
                    got.upw = {o_upward_z, o_upward_y, o_upward_x};
                    got.vw  = {o_view_z, o_view_y, o_view_x};
                    got.shf = {o_shift_z, o_shift_y, o_shift_x};
                    for (int i = 0; i < 3; i++) begin
                        if (ex.rgt[i] !== got.rgt[i]) begin
                            $error("right[%0d] exp %h got %h", i, ex.rgt[i], got.rgt[i]);
                            err_cnt++;
                        end
                        if (ex.upw[i] !== got.upw[i]) begin
                            $error("upward[%0d] exp %h got %h", i, ex.upw[i], got.upw[i]);
                            err_cnt++;
                        end
                        if (ex.vw[i] !== got.vw[i]) begin
                            $error("view[%0d] exp %h got %h", i, ex.vw[i], got.vw[i]);
                            err_cnt++;
                        end
                        if (ex.shf[i] !== got.shf[i]) begin
                            $error("shift[%0d] exp %h got %h", i, ex.shf[i], got.shf[i]);
                            err_cnt++;
                        end
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cnt <= 0;
            else idle_cnt <= idle_cnt + 1;
        end
    end

    // timeout
    always @(posedge i_clk) begin
        if (idle_cnt >= WD_LIMIT) begin
            $display("[look_at_view_matrix_top] ERROR");
            $finish;
        end
    end

    initial begin
        t_setup su;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_ready  = 1'b0;
        {i_cam_x, i_cam_y, i_cam_z}    = '0;
        {i_gaze_x, i_gaze_y, i_gaze_z} = '0;
        {i_up_x, i_up_y, i_up_z}       = '0;
        phase    = PH_NONE;
        hold_src = 1'b0;
        stim_done = 1'b0;
        in_acc   = 1'b0;
        err_cnt  = 0;
        idle_cnt = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // directed: axis-aligned, degenerate and extreme setups
        setup_q.push_back(mk(0, 0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0));
        setup_q.push_back(mk(32'h10000, 32'h20000, 32'h30000, 32'h50000, 0, 0,
                             0, 32'h10000, 0));
        setup_q.push_back(mk(5, 6, 7, 5, 6, 7, 0, 32'h10000, 0));
        setup_q.push_back(mk(0, 0, 0, 0, 32'h10000, 0, 0, 32'h10000, 0));
        setup_q.push_back(mk(0, 0, 0, 0, 0, 32'h10000, 0, 0, 0));
        setup_q.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                             32'h80000000, 32'h80000000, 32'h80000000,
                             32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
        setup_q.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000,
                             32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                             32'h80000000, 32'h7FFFFFFF, 32'h80000000));
        setup_q.push_back(mk(32'h80000000, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 32'h80000000,
                             1, 32'hFFFFFFFF, 1));
        setup_q.push_back(mk(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0,
                             32'hFFFFFFFF, 0, 0));
        setup_q.push_back(mk(32'h7FFF0000, 32'h81230000, 32'h40000000, 0, 1, 0,
                             32'h55555555, 32'hAAAAAAAA, 32'h12345678));
        setup_q.push_back(mk(32'h10000, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0));
        setup_q.push_back(mk(0, 0, 0, 32'h80000000, 0, 0, 0, 0, 32'h80000000));

        // random setups across idle phases
        for (int p = 0; p < 4; p++) begin
            // drain fully before changing phase; source held off meanwhile
            hold_src = 1'b1;
            wait (setup_q.size() == 0 || hold_src);
            hold_src = 1'b0;
            while (setup_q.size() > 0) @(posedge i_clk);
            hold_src = 1'b1;
            while (frame_q.size() > 0) @(posedge i_clk);
            phase = t_phase'(p);
            for (int k = 0; k < RAND_ITEMS / 4; k++) setup_q.push_back(rnd_setup());
            @(negedge i_clk) hold_src = 1'b0;
        end
        while (setup_q.size() > 0) @(posedge i_clk);
        stim_done = 1'b1;
        while (frame_q.size() > 0) @(posedge i_clk);
        repeat (PIPE_LAT + 20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("[look_at_view_matrix_top] OK");
        end else begin
            $display("[look_at_view_matrix_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lkv_pkg.sv
rtl/lkv_isqrt.sv
rtl/lkv_div.sv
rtl/lkv_norm.sv
rtl/look_at_view_matrix_top.sv
sim/tb_look_at_view_matrix_top.sv
